>>> sv/sha1_pkg.sv
`timescale 1ns / 1ps

package sha1_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned NUM_WORDS   = 5;
   localparam int unsigned BLOCK_W     = 512;
   localparam int unsigned FILL_W      = 7;
   localparam int unsigned ROUND_W     = 7;
   localparam int unsigned IDX_W       = 3;

   localparam logic [FILL_W-1:0]  FILL_FULL    = 7'd64;
   localparam logic [FILL_W-1:0]  FILL_LEN_POS = 7'd56;
   localparam logic [ROUND_W-1:0] ROUND_LAST   = 7'd79;
   localparam logic [IDX_W-1:0]   IDX_LAST     = 3'd4;
   localparam logic [7:0]         PAD_MARKER   = 8'h80;

   localparam logic [WORD_W-1:0] IV_WORDS [NUM_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD_MARK,
      ST_PAD_FILL,
      ST_PAD_LEN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         shift_byte;
      byte_src_type byte_src;
      logic         count_len;
      logic         start_round;
      logic         round;
      logic         fold;
      logic         next_word;
      logic         reinit;
   } cmd_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic              round_last;
      logic              word_last;
   } status_type;

   function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] r);
      logic [WORD_W-1:0] k;
      if (r < 7'd20)      k = 32'h5A827999;
      else if (r < 7'd40) k = 32'h6ED9EBA1;
      else if (r < 7'd60) k = 32'h8F1BBCDC;
      else                k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] r,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] f;
      if (r < 7'd20)                    f = (b & c) | (~b & d);
      else if (r < 7'd40 || r >= 7'd60) f = b ^ c ^ d;
      else                              f = (b & c) | (b & d) | (c & d);
      return f;
   endfunction

endpackage

>>> sv/sha1_if.sv
`timescale 1ns / 1ps

interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> sv/sha1_datapath.sv
`timescale 1ns / 1ps

module sha1_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sha1_pkg::cmd_type                      cmd,
   input  logic [7:0]                             data_byte,
   output sha1_pkg::status_type                   status,
   output logic [sha1_pkg::WORD_W-1:0]            digest_word,
   output logic [sha1_pkg::IDX_W-1:0]             word_index,
   output logic                                   last_word
);

   localparam int unsigned WW = sha1_pkg::WORD_W;

   logic [sha1_pkg::BLOCK_W-1:0] buf_ff, buf_in;
   logic [sha1_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [63:0]                  len_ff, len_in;
   logic [WW-1:0]                h_ff [sha1_pkg::NUM_WORDS];
   logic [WW-1:0]                h_in [sha1_pkg::NUM_WORDS];
   logic [WW-1:0]                a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WW-1:0]                a_in, b_in, c_in, d_in, e_in;
   logic [sha1_pkg::ROUND_W-1:0] rnd_ff, rnd_in;
   logic [sha1_pkg::IDX_W-1:0]   idx_ff, idx_in;

   logic [7:0]    byte_mux;
   logic [63:0]   len_sh;
   logic [WW-1:0] w0, w2, w8, w13, w_mix, w_new, t_sum;

   // Window word j holds W[t+j] during round t.
   assign w0  = buf_ff[sha1_pkg::BLOCK_W-1    -: WW];
   assign w2  = buf_ff[sha1_pkg::BLOCK_W-1-64  -: WW];
   assign w8  = buf_ff[sha1_pkg::BLOCK_W-1-256 -: WW];
   assign w13 = buf_ff[sha1_pkg::BLOCK_W-1-416 -: WW];
   assign w_mix = w13 ^ w8 ^ w2 ^ w0;
   assign w_new = {w_mix[WW-2:0], w_mix[WW-1]};

   assign t_sum = {a_ff[WW-6:0], a_ff[WW-1:WW-5]}
                + sha1_pkg::round_f(rnd_ff, b_ff, c_ff, d_ff)
                + e_ff + w0 + sha1_pkg::round_k(rnd_ff);

   // Length bytes go out most significant first, picked by the fill position.
   assign len_sh = len_ff << {fill_ff[2:0], 3'b000};

   always_comb begin
      unique case (cmd.byte_src)
         sha1_pkg::SRC_DATA: byte_mux = data_byte;
         sha1_pkg::SRC_MARK: byte_mux = sha1_pkg::PAD_MARKER;
         sha1_pkg::SRC_ZERO: byte_mux = 8'h00;
         sha1_pkg::SRC_LEN:  byte_mux = len_sh[63:56];
         default:            byte_mux = 8'h00;
      endcase
   end

   always_comb begin
      buf_in  = buf_ff;
      fill_in = fill_ff;
      len_in  = len_ff;
      h_in    = h_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      rnd_in  = rnd_ff;
      idx_in  = idx_ff;

      if (cmd.shift_byte) begin
         buf_in  = {buf_ff[sha1_pkg::BLOCK_W-9:0], byte_mux};
         fill_in = fill_ff + 7'd1;
      end
      if (cmd.count_len) len_in = len_ff + 64'd8;

      if (cmd.start_round) begin
         a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3]; e_in = h_ff[4];
         rnd_in = '0;
      end
      if (cmd.round) begin
         a_in   = t_sum;
         b_in   = a_ff;
         c_in   = {b_ff[1:0], b_ff[WW-1:2]};
         d_in   = c_ff;
         e_in   = d_ff;
         buf_in = {buf_ff[sha1_pkg::BLOCK_W-WW-1:0], w_new};
         rnd_in = rnd_ff + 7'd1;
      end
      if (cmd.fold) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
         fill_in = '0;
      end
      if (cmd.next_word) idx_in = idx_ff + 3'd1;
      if (cmd.reinit) begin
         h_in    = sha1_pkg::IV_WORDS;
         fill_in = '0;
         len_in  = '0;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
         h_ff    <= sha1_pkg::IV_WORDS;
         rnd_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         len_ff  <= len_in;
         h_ff    <= h_in;
         rnd_ff  <= rnd_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
   end

   assign status.fill       = fill_ff;
   assign status.round_last = (rnd_ff == sha1_pkg::ROUND_LAST);
   assign status.word_last  = (idx_ff == sha1_pkg::IDX_LAST);

   assign digest_word = h_ff[idx_ff];
   assign word_index  = idx_ff;
   assign last_word   = (idx_ff == sha1_pkg::IDX_LAST);

endmodule

>>> sv/sha1_ctrl.sv
`timescale 1ns / 1ps

module sha1_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_has_byte,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sha1_pkg::status_type status,
   output sha1_pkg::cmd_type    cmd
);

   sha1_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;   // message ends after this item
   logic pad_ff,  pad_in;    // marker byte already in the block
   logic len_ff,  len_in;    // length bytes already in the block

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1_pkg::ST_IDLE;
         last_ff  <= 1'b0;
         pad_ff   <= 1'b0;
         len_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         pad_ff   <= pad_in;
         len_ff   <= len_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      pad_in    = pad_ff;
      len_in    = len_ff;
      cmd       = '0;
      cmd.byte_src = sha1_pkg::SRC_DATA;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.shift_byte = req_has_byte;
               cmd.count_len  = req_has_byte;
               last_in        = req_last;
               state_in       = sha1_pkg::ST_DISPATCH;
            end
         end
         sha1_pkg::ST_DISPATCH: begin
            if (status.fill == sha1_pkg::FILL_FULL) state_in = sha1_pkg::ST_LOAD;
            else if (last_ff)                       state_in = sha1_pkg::ST_PAD_MARK;
            else                                    state_in = sha1_pkg::ST_IDLE;
         end
         sha1_pkg::ST_LOAD: begin
            cmd.start_round = 1'b1;
            state_in        = sha1_pkg::ST_ROUND;
         end
         sha1_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.round_last) state_in = sha1_pkg::ST_FOLD;
         end
         sha1_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            if (len_ff)       state_in = sha1_pkg::ST_OUT;
            else if (pad_ff)  state_in = sha1_pkg::ST_PAD_FILL;
            else if (last_ff) state_in = sha1_pkg::ST_PAD_MARK;
            else              state_in = sha1_pkg::ST_IDLE;
         end
         sha1_pkg::ST_PAD_MARK: begin
            cmd.shift_byte = 1'b1;
            cmd.byte_src   = sha1_pkg::SRC_MARK;
            pad_in         = 1'b1;
            state_in       = sha1_pkg::ST_PAD_FILL;
         end
         sha1_pkg::ST_PAD_FILL: begin
            if (status.fill == sha1_pkg::FILL_FULL) begin
               state_in = sha1_pkg::ST_LOAD;
            end else if (status.fill == sha1_pkg::FILL_LEN_POS) begin
               state_in = sha1_pkg::ST_PAD_LEN;
            end else begin
               cmd.shift_byte = 1'b1;
               cmd.byte_src   = sha1_pkg::SRC_ZERO;
            end
         end
         sha1_pkg::ST_PAD_LEN: begin
            if (status.fill == sha1_pkg::FILL_FULL) begin
               len_in   = 1'b1;
               state_in = sha1_pkg::ST_LOAD;
            end else begin
               cmd.shift_byte = 1'b1;
               cmd.byte_src   = sha1_pkg::SRC_LEN;
            end
         end
         sha1_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.word_last) begin
                  cmd.reinit = 1'b1;
                  last_in    = 1'b0;
                  pad_in     = 1'b0;
                  len_in     = 1'b0;
                  state_in   = sha1_pkg::ST_IDLE;
               end else begin
                  cmd.next_word = 1'b1;
               end
            end
         end
         default: state_in = sha1_pkg::ST_IDLE;
      endcase
   end

endmodule

>>> sv/sha1_hash_engine.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Beat contents
// req       in   valid/ready    data_byte[7:0], has_byte, last
// rsp       out  valid/ready    digest_word[31:0], word_index[2:0], last_word
//
// A byte beat passes through accept, then dispatch. Every 64th byte adds
// one compression pass: load, 80 rounds on one shared round unit, fold
// into the chaining words. A last beat pads one byte per cycle, apart from
// the fill checks (plus a second compression when the length spills over),
// and then presents the 5 digest words, one beat each.
// Reset is synchronous; it reloads the initial chaining words and clears the
// fill and length counters. The block buffer holds no reset value.
// req_ready is high only in idle; rsp stalls simply hold the current word.

module sha1_hash_engine (
   input  logic              clock,
   input  logic              reset,
   sha1_req_if.sink          req,
   sha1_rsp_if.source        rsp
);

   sha1_pkg::cmd_type    cmd;
   sha1_pkg::status_type status;

   // Sequencer: walks byte intake, padding, compression and digest readout.
   sha1_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_has_byte (req.has_byte),
      .req_last     (req.last),
      .req_ready    (req.ready),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .status       (status),
      .cmd          (cmd)
   );

   // Datapath: 512-bit block window, round registers, chaining words.
   sha1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req.data_byte),
      .status      (status),
      .digest_word (rsp.digest_word),
      .word_index  (rsp.word_index),
      .last_word   (rsp.last_word)
   );

endmodule
